FILE: sv/ssc_pkg.sv
// Shared types, constants and register codes of the sonar scan controller.
package ssc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DANGER_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAN_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JOY_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_JOY_HIGH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_ANGLE = 3'd7;

    localparam logic [1:0] IND_NONE   = 2'd0;
    localparam logic [1:0] IND_SAFE   = 2'd1;
    localparam logic [1:0] IND_DANGER = 2'd2;

    localparam logic       MODE_MANUAL = 1'b0;
    localparam logic       MODE_SWEEP  = 1'b1;

    localparam logic [7:0] ANGLE_LIMIT = 8'd180;
    localparam logic [8:0] RANGE_LIMIT = 9'd511;

    // ceil(2^30 / 1000): exact floor(x / 1000) for every x below 2^20
    localparam int unsigned DIV_SHIFT = 30;
    localparam logic [20:0] DIV_RECIP = 21'd1073742;

    localparam logic [8:0]  RST_DANGER_THR = 9'd30;
    localparam logic [15:0] RST_SWEEP_INT  = 16'd15;
    localparam logic [7:0]  RST_ANGLE_MIN  = 8'd10;
    localparam logic [7:0]  RST_ANGLE_MAX  = 8'd170;
    localparam logic [3:0]  RST_MAN_STEP   = 4'd3;
    localparam logic [9:0]  RST_JOY_LOW    = 10'd450;
    localparam logic [9:0]  RST_JOY_HIGH   = 10'd550;
    localparam logic [7:0]  RST_HOME_ANGLE = 8'd90;
    localparam logic [7:0]  RST_MAN_POS    = 8'd90;
    localparam logic [7:0]  RST_SWEEP_POS  = 8'd10;

    typedef struct packed {
        logic [8:0]  danger_thr;
        logic [15:0] sweep_int;
        logic [7:0]  angle_min;
        logic [7:0]  angle_max;
        logic [3:0]  man_step;
        logic [9:0]  joy_low;
        logic [9:0]  joy_high;
        logic [7:0]  home_angle;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [9:0]  joy;
        logic        center;
        logic [31:0] now_ms;
        logic        echo_hit;
        logic [8:0]  dist_cm;
    } t_item;

endpackage

FILE: sv/ssc_front.sv
// Front end: request intake, mode button edge detection and echo distance.
module ssc_front
    import ssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_button_level,
    input  logic [9:0]  i_joystick_x,
    input  logic        i_center_pressed,
    input  logic [31:0] i_now_ms,
    input  logic [14:0] i_echo_width_us,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic        r_prev_button;
    logic        r_mode;
    logic        n_mode;
    logic [19:0] us_x17;
    logic [40:0] prod;
    logic [10:0] quot;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign n_mode = (!i_button_level && r_prev_button) ? !r_mode : r_mode;

    assign us_x17 = {1'b0, i_echo_width_us, 4'b0} + {5'b0, i_echo_width_us};
    assign prod   = {21'b0, us_x17} * {20'b0, DIV_RECIP};
    assign quot   = prod[DIV_SHIFT+10:DIV_SHIFT];

    always_comb begin
        o_item.mode     = n_mode;
        o_item.joy      = i_joystick_x;
        o_item.center   = i_center_pressed;
        o_item.now_ms   = i_now_ms;
        o_item.echo_hit = (i_echo_width_us != 15'd0);
        o_item.dist_cm  = (quot > {2'b0, RANGE_LIMIT}) ? RANGE_LIMIT : quot[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_button <= 1'b1;
            r_mode        <= MODE_MANUAL;
        end else if (o_push) begin
            r_prev_button <= i_button_level;
            r_mode        <= n_mode;
        end
    end

endmodule

FILE: sv/ssc_queue.sv
// Two-entry queue between front end and back end.
module ssc_queue
    import ssc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nempty,
    output t_item o_item
);

    t_item      r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full   = (r_count == 2'd2);
    assign o_nempty = (r_count != 2'd0);
    assign o_item   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/ssc_back.sv
// Back end: servo position update, sweep timing, range and indicator, result register.
module ssc_back
    import ssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_nempty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_servo_angle,
    output logic        o_servo_update,
    output logic [8:0]  o_distance_cm,
    output logic [1:0]  o_indicator,
    output logic        o_scan_mode
);

    logic        r_valid;
    logic [7:0]  r_man_pos;
    logic [7:0]  r_sweep_pos;
    logic        r_sweep_down;
    logic [31:0] r_last_ms;
    logic [8:0]  r_range;
    logic [1:0]  r_light;

    logic [7:0]  n_man_pos;
    logic [7:0]  n_sweep_pos;
    logic        n_sweep_down;
    logic [31:0] n_last_ms;
    logic [8:0]  n_range;
    logic [1:0]  n_light;
    logic [7:0]  angle_out;
    logic        updated;

    logic [31:0] elapsed;
    logic [7:0]  home;
    logic [7:0]  mbase;
    logic [8:0]  msum;
    logic [7:0]  sp;

    assign o_pop   = i_q_nempty && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    assign elapsed = i_item.now_ms - r_last_ms;
    assign home    = (i_cfg.home_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : i_cfg.home_angle;
    assign mbase   = i_item.center ? home : r_man_pos;
    assign msum    = {1'b0, mbase} + {5'b0, i_cfg.man_step};

    always_comb begin
        n_man_pos    = r_man_pos;
        n_sweep_pos  = r_sweep_pos;
        n_sweep_down = r_sweep_down;
        n_last_ms    = r_last_ms;
        n_range      = r_range;
        n_light      = r_light;
        updated      = 1'b0;
        sp           = r_sweep_pos;
        angle_out    = r_sweep_pos;
        if (i_item.mode == MODE_SWEEP) begin
            if (elapsed >= {16'b0, i_cfg.sweep_int}) begin
                updated   = 1'b1;
                n_last_ms = i_item.now_ms;
                if (r_sweep_down) begin
                    sp = (r_sweep_pos > 8'd0) ? r_sweep_pos - 8'd1 : r_sweep_pos;
                end else begin
                    sp = (r_sweep_pos < ANGLE_LIMIT) ? r_sweep_pos + 8'd1 : r_sweep_pos;
                end
                if (sp <= i_cfg.angle_min || sp >= i_cfg.angle_max || sp == 8'd0 ||
                    sp >= ANGLE_LIMIT) begin
                    n_sweep_down = !r_sweep_down;
                end
                n_sweep_pos = sp;
            end
        end else begin
            updated = 1'b1;
            if (i_item.joy < i_cfg.joy_low && mbase < i_cfg.angle_max) begin
                n_man_pos = (msum > {1'b0, ANGLE_LIMIT}) ? ANGLE_LIMIT : msum[7:0];
            end else if (i_item.joy > i_cfg.joy_high && mbase > i_cfg.angle_min) begin
                n_man_pos = (mbase > {4'b0, i_cfg.man_step}) ?
                            mbase - {4'b0, i_cfg.man_step} : 8'd0;
            end else begin
                n_man_pos = mbase;
            end
            angle_out = n_man_pos;
        end
        if (updated && i_item.echo_hit) begin
            n_range = i_item.dist_cm;
            n_light = (i_item.dist_cm < i_cfg.danger_thr) ? IND_DANGER : IND_SAFE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_man_pos    <= RST_MAN_POS;
            r_sweep_pos  <= RST_SWEEP_POS;
            r_sweep_down <= 1'b0;
            r_last_ms    <= 32'd0;
            r_range      <= 9'd0;
            r_light      <= IND_NONE;
        end else begin
            if (o_pop) begin
                r_valid      <= 1'b1;
                r_man_pos    <= n_man_pos;
                r_sweep_pos  <= n_sweep_pos;
                r_sweep_down <= n_sweep_down;
                r_last_ms    <= n_last_ms;
                r_range      <= n_range;
                r_light      <= n_light;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_servo_angle  <= angle_out;
            o_servo_update <= updated;
            o_distance_cm  <= n_range;
            o_indicator    <= n_light;
            o_scan_mode    <= i_item.mode;
        end
    end

endmodule

FILE: sv/sonar_scan_controller.sv
// Top level of the sonar scan controller: configuration registers and front/queue/back.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  button, joystick, center, time, echo
//   result    out        o_valid / i_stall  angle, update, distance, indicator, mode
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_wdata
//
// One request per cycle unless a result stall fills the queue; each request passes a
// queue slot, then the back end updates position and timing into the result register.
// Synchronous reset restores the register defaults and the power-on positions.
// A stalled result holds; the two-entry queue stalls the request side only when full.
module sonar_scan_controller
    import ssc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_button_level,
    input  logic [9:0]            i_joystick_x,
    input  logic                  i_center_pressed,
    input  logic [31:0]           i_now_ms,
    input  logic [14:0]           i_echo_width_us,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_servo_angle,
    output logic                  o_servo_update,
    output logic [8:0]            o_distance_cm,
    output logic [1:0]            o_indicator,
    output logic                  o_scan_mode,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_nempty;
    logic  push;
    logic  pop;
    t_item front_item;
    t_item head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.danger_thr <= RST_DANGER_THR;
            r_cfg.sweep_int  <= RST_SWEEP_INT;
            r_cfg.angle_min  <= RST_ANGLE_MIN;
            r_cfg.angle_max  <= RST_ANGLE_MAX;
            r_cfg.man_step   <= RST_MAN_STEP;
            r_cfg.joy_low    <= RST_JOY_LOW;
            r_cfg.joy_high   <= RST_JOY_HIGH;
            r_cfg.home_angle <= RST_HOME_ANGLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DANGER_THR: r_cfg.danger_thr <= i_cfg_wdata[8:0];
                CFG_SWEEP_INT:  r_cfg.sweep_int  <= i_cfg_wdata;
                CFG_ANGLE_MIN:  r_cfg.angle_min  <= i_cfg_wdata[7:0];
                CFG_ANGLE_MAX:  r_cfg.angle_max  <= i_cfg_wdata[7:0];
                CFG_MAN_STEP:   r_cfg.man_step   <= i_cfg_wdata[3:0];
                CFG_JOY_LOW:    r_cfg.joy_low    <= i_cfg_wdata[9:0];
                CFG_JOY_HIGH:   r_cfg.joy_high   <= i_cfg_wdata[9:0];
                CFG_HOME_ANGLE: r_cfg.home_angle <= i_cfg_wdata[7:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    ssc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_button_level   (i_button_level),
        .i_joystick_x     (i_joystick_x),
        .i_center_pressed (i_center_pressed),
        .i_now_ms         (i_now_ms),
        .i_echo_width_us  (i_echo_width_us),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (front_item)
    );

    ssc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_item   (head_item)
    );

    ssc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_nempty     (q_nempty),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_servo_angle  (o_servo_angle),
        .o_servo_update (o_servo_update),
        .o_distance_cm  (o_distance_cm),
        .o_indicator    (o_indicator),
        .o_scan_mode    (o_scan_mode)
    );

endmodule

FILE: tb/sv/tb_sonar_scan_controller.sv
// Testbench for the sonar scan controller: random passes checked against a per-pass predictor.
module tb_sonar_scan_controller;
    import ssc_pkg::*;

    typedef struct packed {
        logic [7:0] angle;
        logic       update;
        logic [8:0] dist_cm;
        logic [1:0] ind;
        logic       mode;
    } t_pass;

    class scan_pass_board;
        t_cfg        cfg;
        logic        prev_btn;
        logic        mode;
        logic        sweep_down;
        logic [7:0]  man_pos;
        logic [7:0]  sweep_pos;
        logic [31:0] last_step;
        logic [8:0]  range_cm;
        logic [1:0]  light;
        t_pass       pass_outcomes[$];
        int unsigned faults;

        function new();
            cfg.danger_thr = RST_DANGER_THR;
            cfg.sweep_int  = RST_SWEEP_INT;
            cfg.angle_min  = RST_ANGLE_MIN;
            cfg.angle_max  = RST_ANGLE_MAX;
            cfg.man_step   = RST_MAN_STEP;
            cfg.joy_low    = RST_JOY_LOW;
            cfg.joy_high   = RST_JOY_HIGH;
            cfg.home_angle = RST_HOME_ANGLE;
            prev_btn   = 1'b1;
            mode       = MODE_MANUAL;
            sweep_down = 1'b0;
            man_pos    = RST_MAN_POS;
            sweep_pos  = RST_SWEEP_POS;
            last_step  = '0;
            range_cm   = '0;
            light      = IND_NONE;
            faults     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_DANGER_THR: cfg.danger_thr = v[8:0];
                CFG_SWEEP_INT:  cfg.sweep_int  = v[15:0];
                CFG_ANGLE_MIN:  cfg.angle_min  = v[7:0];
                CFG_ANGLE_MAX:  cfg.angle_max  = v[7:0];
                CFG_MAN_STEP:   cfg.man_step   = v[3:0];
                CFG_JOY_LOW:    cfg.joy_low    = v[9:0];
                CFG_JOY_HIGH:   cfg.joy_high   = v[9:0];
                CFG_HOME_ANGLE: cfg.home_angle = v[7:0];
                default: ;
            endcase
        endfunction

        function void take_echo(logic [14:0] us);
            logic [19:0] d;
            if (us != 0) begin
                d = (20'(us) * 20'd17) / 20'd1000;
                range_cm = (d > RANGE_LIMIT) ? RANGE_LIMIT : d[8:0];
                light = (range_cm < cfg.danger_thr) ? IND_DANGER : IND_SAFE;
            end
        endfunction

        function void note_request(logic btn, logic [9:0] joy, logic ctr,
                                   logic [31:0] now, logic [14:0] echo);
            t_pass       res;
            logic [31:0] elapsed;
            logic [7:0]  pos;
            logic [8:0]  sum;
            res = '0;
            if (!btn && prev_btn)
                mode = ~mode;
            prev_btn = btn;
            if (mode == MODE_SWEEP) begin
                res.angle = sweep_pos;
                elapsed = now - last_step;
                if (elapsed >= {16'd0, cfg.sweep_int}) begin
                    pos = sweep_pos;
                    last_step = now;
                    res.update = 1'b1;
                    take_echo(echo);
                    if (sweep_down) begin
                        if (pos > 0)
                            pos = pos - 8'd1;
                    end else if (pos < ANGLE_LIMIT) begin
                        pos = pos + 8'd1;
                    end
                    if (pos <= cfg.angle_min || pos >= cfg.angle_max || pos == 0
                        || pos >= ANGLE_LIMIT)
                        sweep_down = ~sweep_down;
                    sweep_pos = pos;
                end
            end else begin
                pos = man_pos;
                if (ctr)
                    pos = (cfg.home_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : cfg.home_angle;
                if (joy < cfg.joy_low && pos < cfg.angle_max) begin
                    sum = {1'b0, pos} + {5'd0, cfg.man_step};
                    pos = (sum > {1'b0, ANGLE_LIMIT}) ? ANGLE_LIMIT : sum[7:0];
                end else if (joy > cfg.joy_high && pos > cfg.angle_min) begin
                    pos = (pos > cfg.man_step) ? pos - {4'd0, cfg.man_step} : 8'd0;
                end
                man_pos = pos;
                res.angle = pos;
                res.update = 1'b1;
                take_echo(echo);
            end
            res.dist_cm = range_cm;
            res.ind     = light;
            res.mode    = mode;
            pass_outcomes.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                faults++;
            end
        endfunction

        function void check_pass(logic [7:0] angle, logic update, logic [8:0] dist_cm,
                                 logic [1:0] ind, logic mode_out);
            t_pass want;
            if (pass_outcomes.size() == 0) begin
                $display("%0t result with no request waiting: expected none, actual angle %0d",
                         $time, angle);
                faults++;
            end else begin
                want = pass_outcomes.pop_front();
                check_field("servo_angle", 32'(want.angle), 32'(angle));
                check_field("servo_update", 32'(want.update), 32'(update));
                check_field("distance_cm", 32'(want.dist_cm), 32'(dist_cm));
                check_field("indicator", 32'(want.ind), 32'(ind));
                check_field("scan_mode", 32'(want.mode), 32'(mode_out));
            end
        endfunction

        function void close_out();
            if (pass_outcomes.size() != 0) begin
                $display("%0t results missing: expected %0d more, actual 0", $time,
                         pass_outcomes.size());
                faults += pass_outcomes.size();
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_button_level;
    logic [9:0]            i_joystick_x;
    logic                  i_center_pressed;
    logic [31:0]           i_now_ms;
    logic [14:0]           i_echo_width_us;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_servo_angle;
    logic                  o_servo_update;
    logic [8:0]            o_distance_cm;
    logic [1:0]            o_indicator;
    logic                  o_scan_mode;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    scan_pass_board sb;
    logic           btn_level;
    logic [31:0]    clock_ms;
    int             steady_left;

    sonar_scan_controller u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_button_level   (i_button_level),
        .i_joystick_x     (i_joystick_x),
        .i_center_pressed (i_center_pressed),
        .i_now_ms         (i_now_ms),
        .i_echo_width_us  (i_echo_width_us),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_servo_angle    (o_servo_angle),
        .o_servo_update   (o_servo_update),
        .o_distance_cm    (o_distance_cm),
        .o_indicator      (o_indicator),
        .o_scan_mode      (o_scan_mode),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request(i_button_level, i_joystick_x, i_center_pressed,
                                i_now_ms, i_echo_width_us);
            if (o_valid && !i_stall)
                sb.check_pass(o_servo_angle, o_servo_update, o_distance_cm,
                              o_indicator, o_scan_mode);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic drive_payload(input logic btn, input logic [9:0] joy, input logic ctr,
                                 input logic [31:0] now, input logic [14:0] echo);
        i_button_level   <= btn;
        i_joystick_x     <= joy;
        i_center_pressed <= ctr;
        i_now_ms         <= now;
        i_echo_width_us  <= echo;
    endtask

    task automatic send_request(input logic btn, input logic [9:0] joy, input logic ctr,
                                input logic [31:0] now, input logic [14:0] echo);
        @(negedge i_clk);
        i_valid <= 1'b1;
        drive_payload(btn, joy, ctr, now, echo);
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic idle_requests(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            drive_payload(1'($urandom), 10'($urandom), 1'($urandom), $urandom,
                          15'($urandom));
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pass_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] data;
        data = value | (16'($urandom) << width);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int thr, input int ivl, input int amin, input int amax,
                                 input int step, input int jlo, input int jhi,
                                 input int home);
        settle();
        write_reg(CFG_DANGER_THR, 16'(thr), 9);
        write_reg(CFG_SWEEP_INT, 16'(ivl), 16);
        write_reg(CFG_ANGLE_MIN, 16'(amin), 8);
        write_reg(CFG_ANGLE_MAX, 16'(amax), 8);
        write_reg(CFG_MAN_STEP, 16'(step), 4);
        write_reg(CFG_JOY_LOW, 16'(jlo), 10);
        write_reg(CFG_JOY_HIGH, 16'(jhi), 10);
        write_reg(CFG_HOME_ANGLE, 16'(home), 8);
    endtask

    task automatic random_pass(input int flip_pct);
        int          r;
        int          j;
        int          gap;
        logic        ctr;
        logic [14:0] echo;
        if ($urandom_range(0, 99) < flip_pct)
            btn_level = ~btn_level;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = $urandom;
        else if (r >= 6)
            clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(sb.cfg.sweep_int) + 2));
        r = $urandom_range(0, 99);
        if (r < 40)
            j = $urandom_range(0, 1023);
        else if (r < 70)
            j = int'(sb.cfg.joy_low) + int'($urandom_range(0, 4)) - 2;
        else
            j = int'(sb.cfg.joy_high) + int'($urandom_range(0, 4)) - 2;
        if (j < 0)
            j = 0;
        if (j > 1023)
            j = 1023;
        ctr = ($urandom_range(0, 99) < 6);
        r = $urandom_range(0, 99);
        if (r < 20)
            echo = '0;
        else if (r < 50)
            echo = 15'($urandom_range(1, 3000));
        else if (r < 90)
            echo = 15'($urandom_range(0, 25000));
        else
            echo = 15'($urandom_range(0, 32767));
        send_request(btn_level, 10'(j), ctr, clock_ms, echo);
        if (steady_left > 0) begin
            steady_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 3)
                steady_left = $urandom_range(20, 60);
            gap = pick_gap();
        end
        idle_requests(gap);
    endtask

    task automatic run_phase(input int count, input int flip_pct);
        for (int i = 0; i < count; i++) begin
            random_pass(flip_pct);
            if (i == count / 2)
                settle();
        end
    endtask

    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            repeat (($urandom_range(0, 99) < 5) ? $urandom_range(80, 200)
                                                : $urandom_range(1, 10))
                @(negedge i_clk) i_stall <= 1'b0;
            repeat (pick_gap()) @(negedge i_clk) i_stall <= 1'b1;
        end
    end

    initial begin
        #12_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        sb = new();
        btn_level = 1'b1;
        clock_ms = '0;
        steady_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_button_level = 1'b1;
        i_joystick_x = '0;
        i_center_pressed = 1'b0;
        i_now_ms = '0;
        i_echo_width_us = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(1'b1, 10'd500, 1'b0, 32'd0, 15'd0);
        send_request(1'b1, 10'd0, 1'b1, 32'd1, 15'd1000);
        send_request(1'b1, 10'd1023, 1'b0, 32'd2, 15'd25000);
        send_request(1'b1, 10'd449, 1'b0, 32'd3, 15'd32767);
        send_request(1'b1, 10'd551, 1'b1, 32'd4, 15'd1764);
        send_request(1'b1, 10'd450, 1'b0, 32'd5, 15'd1765);
        send_request(1'b0, 10'd550, 1'b0, 32'd6, 15'd0);
        send_request(1'b0, 10'd500, 1'b0, 32'd15, 15'd500);
        send_request(1'b1, 10'd500, 1'b0, 32'd29, 15'd0);
        send_request(1'b1, 10'd500, 1'b0, 32'hFFFF_FFF0, 15'd100);
        send_request(1'b1, 10'd500, 1'b0, 32'h0000_0002, 15'd30000);
        send_request(1'b0, 10'd0, 1'b0, 32'd3, 15'd0);
        send_request(1'b0, 10'd1023, 1'b0, 32'd4, 15'd29);
        send_request(1'b1, 10'd1023, 1'b1, 32'd5, 15'd59);
        btn_level = 1'b1;
        clock_ms = 32'd5;
        run_phase(150, 4);

        // walk the sweep across both hard endpoints
        apply_setting(0, 0, 0, 255, 15, 1023, 0, 255);
        run_phase(400, 1);
        apply_setting(511, 65535, 255, 0, 0, 0, 1023, 180);
        run_phase(150, 4);
        apply_setting(200, 1, 170, 10, 7, 300, 700, 0);
        run_phase(150, 4);
        repeat (6) begin
            apply_setting($urandom_range(0, 511),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 40),
                          $urandom_range(0, 180),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 180),
                          $urandom_range(0, 15), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 255));
            run_phase(115, 4);
        end

        settle();
        repeat (6) @(posedge i_clk);
        sb.close_out();
        if (sb.faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
